/* hw/rtl/xwc_pkg.sv */
// shared types, constants and helpers of the xml well-formedness checker
package xwc_pkg;

    // default build sizes
    localparam int MAX_DEPTH_DEF    = 16;
    localparam int MAX_NAME_LEN_DEF = 32;

    // character codes
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // markup prefix matcher progress inside a tag name
    localparam logic [3:0] PP_START     = 4'd0;
    localparam logic [3:0] PP_BANG      = 4'd1;
    localparam logic [3:0] PP_DASH      = 4'd2;
    localparam logic [3:0] PP_BRACKET   = 4'd3;
    localparam logic [3:0] PP_CDATA_END = 4'd8;
    localparam logic [3:0] PP_DEAD      = 4'd15;

    // parse phase, one-hot
    typedef enum logic [12:0] {
        PH_TOP          = 13'b0000000000001,
        PH_LT           = 13'b0000000000010,
        PH_NAME_OPEN    = 13'b0000000000100,
        PH_NAME_CLOSE   = 13'b0000000001000,
        PH_CLOSE_WS     = 13'b0000000010000,
        PH_ATTR_GAP     = 13'b0000000100000,
        PH_ATTR_NAME    = 13'b0000001000000,
        PH_VALUE_WS     = 13'b0000010000000,
        PH_QUOTED       = 13'b0000100000000,
        PH_SELF_SLASH   = 13'b0001000000000,
        PH_SKIP_COMMENT = 13'b0010000000000,
        PH_SKIP_PI      = 13'b0100000000000,
        PH_SKIP_CDATA   = 13'b1000000000000
    } phase_t;

    // memory access requests from the parser to the name stack
    typedef struct packed {
        logic rd_en;
        logic name_we;
        logic len_we;
    } stack_ctl_t;

    // one verdict
    typedef struct packed {
        logic over_capacity;
        logic doc_valid;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic ends_name(input logic [7:0] c);
        return is_ws(c) || (c == CH_GT) || (c == CH_SLASH) || (c == CH_EQ);
    endfunction

    // letters of the CDATA keyword
    function automatic logic [7:0] cdata_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h43;
            3'd1:    ch = 8'h44;
            3'd2:    ch = 8'h41;
            3'd3:    ch = 8'h54;
            3'd4:    ch = 8'h41;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* hw/rtl/xwc_ram.sv */
// generic single-port-write, registered-read ram
module xwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/xwc_name_stack.sv */
// stack of open tag names and their lengths, held in two rams
module xwc_name_stack
    import xwc_pkg::*;
#(
    parameter int MAX_DEPTH    = MAX_DEPTH_DEF,
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF,
    localparam int RW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
    localparam int CW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1,
    localparam int LW = $clog2(MAX_NAME_LEN + 1),
    localparam int ND = MAX_DEPTH * MAX_NAME_LEN,
    localparam int AW = (ND > 1) ? $clog2(ND) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  stack_ctl_t    ctl,
    input  logic [RW-1:0] name_wrow,
    input  logic [CW-1:0] name_wcol,
    input  logic [7:0]    name_wdata,
    input  logic [RW-1:0] len_wrow,
    input  logic [LW-1:0] len_wdata,
    input  logic [RW-1:0] rd_row,
    input  logic [CW-1:0] rd_col,
    output logic [7:0]    top_byte,
    output logic [LW-1:0] top_len
);

    logic [AW-1:0] name_waddr;
    logic [AW-1:0] name_raddr;
    logic [LW-1:0] len_rdata;
    logic          fwd_hit_reg;
    logic [LW-1:0] fwd_len_reg;

    // flat byte address: row times name length plus column
    assign name_waddr = AW'(name_wrow) * AW'(MAX_NAME_LEN) + AW'(name_wcol);
    assign name_raddr = AW'(rd_row) * AW'(MAX_NAME_LEN) + AW'(rd_col);

    xwc_ram #(
        .WIDTH (8),
        .DEPTH (ND)
    ) u_name_ram (
        .clk   (clk),
        .we    (ctl.name_we),
        .waddr (name_waddr),
        .wdata (name_wdata),
        .re    (ctl.rd_en),
        .raddr (name_raddr),
        .rdata (top_byte)
    );

    xwc_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_DEPTH)
    ) u_len_ram (
        .clk   (clk),
        .we    (ctl.len_we),
        .waddr (len_wrow),
        .wdata (len_wdata),
        .re    (ctl.rd_en),
        .raddr (rd_row),
        .rdata (len_rdata)
    );

    // forward a length written in the same cycle as its prefetch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (ctl.rd_en)
        begin
            fwd_hit_reg <= ctl.len_we && (len_wrow == rd_row);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            fwd_len_reg <= len_wdata;
        end
    end

    assign top_len = fwd_hit_reg ? fwd_len_reg : len_rdata;

endmodule

/* hw/rtl/xwc_parser.sv */
// byte parser: phase, counters and flags, with prefetch of the stack top
module xwc_parser
    import xwc_pkg::*;
#(
    parameter int MAX_DEPTH    = MAX_DEPTH_DEF,
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF,
    localparam int DW = $clog2(MAX_DEPTH + 1),
    localparam int RW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
    localparam int PW = $clog2(MAX_NAME_LEN + 2),
    localparam int CW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1,
    localparam int LW = $clog2(MAX_NAME_LEN + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    c,
    input  logic          last,
    input  logic [7:0]    top_byte,
    input  logic [LW-1:0] top_len,
    output stack_ctl_t    ctl,
    output logic [RW-1:0] name_wrow,
    output logic [CW-1:0] name_wcol,
    output logic [7:0]    name_wdata,
    output logic [RW-1:0] len_wrow,
    output logic [LW-1:0] len_wdata,
    output logic [RW-1:0] rd_row,
    output logic [CW-1:0] rd_col,
    output logic          res_push,
    output result_t       res
);

    localparam logic [PW-1:0] NAME_MAX = PW'(MAX_NAME_LEN);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    phase_t        phase_reg, phase_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          mis_reg, mis_next;
    logic          quote_reg, quote_next;
    logic [3:0]    pp_reg, pp_next;
    logic          err_reg, err_next;
    logic          ovf_reg, ovf_next;

    phase_t        phase_t1;
    logic [DW-1:0] depth_t1;
    logic [PW-1:0] pos_t1;
    logic          err_t1;
    logic          ovf_t1;

    logic [PW-1:0] eff_pos;
    logic [3:0]    eff_pp;
    logic [3:0]    np;
    logic          skip_go;
    phase_t        skip_ph;
    logic [PW-1:0] pos_inc;
    logic          gap_go;
    logic          cws_go;
    logic          name_we;
    logic          len_we;
    logic [7:0]    quote_ch;
    logic [7:0]    skip_ch;

    // next state for one byte
    always_comb
    begin
        phase_t1   = phase_reg;
        depth_t1   = depth_reg;
        pos_t1     = pos_reg;
        mis_next   = mis_reg;
        quote_next = quote_reg;
        pp_next    = pp_reg;
        err_t1     = err_reg;
        ovf_t1     = ovf_reg;
        eff_pos    = (phase_reg == PH_LT) ? '0 : pos_reg;
        eff_pp     = (phase_reg == PH_LT) ? PP_START : pp_reg;
        np         = PP_DEAD;
        skip_go    = 1'b0;
        skip_ph    = PH_SKIP_PI;
        pos_inc    = eff_pos + ((eff_pos <= NAME_MAX) ? PW'(1) : PW'(0));
        gap_go     = 1'b0;
        cws_go     = 1'b0;
        name_we    = 1'b0;
        len_we     = 1'b0;
        quote_ch   = quote_reg ? CH_SQUOTE : CH_DQUOTE;
        skip_ch    = (phase_reg == PH_SKIP_COMMENT) ? CH_DASH : CH_RBRACK;

        if (!err_reg)
        begin
            case (phase_reg)
                PH_TOP:
                begin
                    if (c == CH_LT)
                    begin
                        phase_t1 = PH_LT;
                    end
                    else
                    begin
                        err_t1 = 1'b1;
                    end
                end
                PH_LT, PH_NAME_OPEN:
                begin
                    if ((phase_reg == PH_LT) && (c == CH_SLASH))
                    begin
                        phase_t1 = PH_NAME_CLOSE;
                        pos_t1   = '0;
                        mis_next = (depth_reg == '0);
                    end
                    else
                    begin
                        phase_t1 = PH_NAME_OPEN;
                        pos_t1   = eff_pos;
                        pp_next  = eff_pp;
                        if (ends_name(c))
                        begin
                            // tag name complete
                            if (eff_pos == '0)
                            begin
                                err_t1 = 1'b1;
                            end
                            else if (eff_pos > NAME_MAX)
                            begin
                                err_t1 = 1'b1;
                                ovf_t1 = 1'b1;
                            end
                            else
                            begin
                                gap_go = 1'b1;
                            end
                        end
                        else
                        begin
                            // markup prefix recognition
                            if (eff_pp == PP_START)
                            begin
                                if (c == CH_BANG)
                                begin
                                    np = PP_BANG;
                                end
                                else if (c == CH_QMARK)
                                begin
                                    skip_go = 1'b1;
                                    skip_ph = PH_SKIP_PI;
                                end
                            end
                            else if (eff_pp == PP_BANG)
                            begin
                                if (c == CH_DASH)
                                begin
                                    np = PP_DASH;
                                end
                                else if (c == CH_LBRACK)
                                begin
                                    np = PP_BRACKET;
                                end
                            end
                            else if (eff_pp == PP_DASH)
                            begin
                                if (c == CH_DASH)
                                begin
                                    skip_go = 1'b1;
                                    skip_ph = PH_SKIP_COMMENT;
                                end
                            end
                            else if ((eff_pp >= PP_BRACKET) && (eff_pp < PP_CDATA_END))
                            begin
                                if (c == cdata_char(3'(eff_pp - PP_BRACKET)))
                                begin
                                    np = eff_pp + 4'd1;
                                end
                            end
                            else if (eff_pp == PP_CDATA_END)
                            begin
                                if (c == CH_LBRACK)
                                begin
                                    skip_go = 1'b1;
                                    skip_ph = PH_SKIP_CDATA;
                                end
                            end

                            if (skip_go)
                            begin
                                phase_t1 = skip_ph;
                                pp_next  = PP_START;
                            end
                            else
                            begin
                                pp_next = np;
                                name_we = (depth_reg < DEPTH_MAX) && (eff_pos < NAME_MAX);
                                pos_t1  = pos_inc;
                                if ((pos_inc > NAME_MAX) && (np == PP_DEAD))
                                begin
                                    err_t1 = 1'b1;
                                    ovf_t1 = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_NAME_CLOSE:
                begin
                    if (ends_name(c))
                    begin
                        if (pos_reg == '0)
                        begin
                            err_t1 = 1'b1;
                        end
                        else if (pos_reg > NAME_MAX)
                        begin
                            err_t1 = 1'b1;
                            ovf_t1 = 1'b1;
                        end
                        else
                        begin
                            mis_next = mis_reg || (depth_reg == '0) ||
                                       (pos_reg != PW'(top_len));
                            cws_go   = 1'b1;
                        end
                    end
                    else
                    begin
                        // compare against the prefetched byte of the top name
                        if ((depth_reg == '0) || (pos_reg >= PW'(top_len)) ||
                            (top_byte != c))
                        begin
                            mis_next = 1'b1;
                        end
                        pos_t1 = pos_inc;
                        if (pos_inc > NAME_MAX)
                        begin
                            err_t1 = 1'b1;
                            ovf_t1 = 1'b1;
                        end
                    end
                end
                PH_CLOSE_WS:
                begin
                    cws_go = 1'b1;
                end
                PH_ATTR_GAP:
                begin
                    gap_go = 1'b1;
                end
                PH_ATTR_NAME:
                begin
                    if (c == CH_EQ)
                    begin
                        phase_t1 = PH_VALUE_WS;
                    end
                    else if (is_ws(c))
                    begin
                        err_t1 = 1'b1;
                    end
                end
                PH_VALUE_WS:
                begin
                    if (c == CH_DQUOTE)
                    begin
                        quote_next = 1'b0;
                        phase_t1   = PH_QUOTED;
                    end
                    else if (c == CH_SQUOTE)
                    begin
                        quote_next = 1'b1;
                        phase_t1   = PH_QUOTED;
                    end
                    else if (!is_ws(c))
                    begin
                        err_t1 = 1'b1;
                    end
                end
                PH_QUOTED:
                begin
                    if (c == quote_ch)
                    begin
                        phase_t1 = PH_ATTR_GAP;
                    end
                end
                PH_SELF_SLASH:
                begin
                    if (c == CH_GT)
                    begin
                        phase_t1 = PH_TOP;
                    end
                    else
                    begin
                        err_t1 = 1'b1;
                    end
                end
                PH_SKIP_COMMENT, PH_SKIP_CDATA:
                begin
                    if (c == skip_ch)
                    begin
                        if (pp_reg < 4'd2)
                        begin
                            pp_next = pp_reg + 4'd1;
                        end
                    end
                    else if ((c == CH_GT) && (pp_reg == 4'd2))
                    begin
                        phase_t1 = PH_TOP;
                    end
                    else
                    begin
                        pp_next = 4'd0;
                    end
                end
                PH_SKIP_PI:
                begin
                    if (c == CH_QMARK)
                    begin
                        pp_next = 4'd1;
                    end
                    else if ((c == CH_GT) && (pp_reg == 4'd1))
                    begin
                        phase_t1 = PH_TOP;
                    end
                    else
                    begin
                        pp_next = 4'd0;
                    end
                end
                default:
                begin
                    err_t1 = 1'b1;
                end
            endcase

            // between attributes, or right after the tag name
            if (gap_go)
            begin
                if (is_ws(c))
                begin
                    phase_t1 = PH_ATTR_GAP;
                end
                else if (c == CH_GT)
                begin
                    if (depth_reg >= DEPTH_MAX)
                    begin
                        err_t1 = 1'b1;
                        ovf_t1 = 1'b1;
                    end
                    else
                    begin
                        len_we   = 1'b1;
                        depth_t1 = depth_reg + DW'(1);
                        phase_t1 = PH_TOP;
                    end
                end
                else if (c == CH_SLASH)
                begin
                    phase_t1 = PH_SELF_SLASH;
                end
                else if (c == CH_EQ)
                begin
                    phase_t1 = PH_VALUE_WS;
                end
                else
                begin
                    phase_t1 = PH_ATTR_NAME;
                end
            end

            // after a close tag name
            if (cws_go)
            begin
                if (is_ws(c))
                begin
                    phase_t1 = PH_CLOSE_WS;
                end
                else if ((c == CH_GT) && !mis_next && (depth_reg != '0))
                begin
                    depth_t1 = depth_reg - DW'(1);
                    phase_t1 = PH_TOP;
                end
                else
                begin
                    err_t1 = 1'b1;
                end
            end
        end
    end

    // verdict on the last byte, then back to the reset state
    always_comb
    begin
        res.doc_valid     = !err_t1 && (phase_t1 == PH_TOP) && (depth_t1 == '0);
        res.over_capacity = ovf_t1;
        res_push          = accept && last;
        if (last)
        begin
            phase_next = PH_TOP;
            depth_next = '0;
            pos_next   = '0;
            err_next   = 1'b0;
            ovf_next   = 1'b0;
        end
        else
        begin
            phase_next = phase_t1;
            depth_next = depth_t1;
            pos_next   = pos_t1;
            err_next   = err_t1;
            ovf_next   = ovf_t1;
        end
    end

    // stack requests: writes now, prefetch for the next byte
    always_comb
    begin
        ctl.rd_en   = accept;
        ctl.name_we = accept && name_we;
        ctl.len_we  = accept && len_we;
        name_wrow   = RW'(depth_reg);
        name_wcol   = CW'(eff_pos);
        name_wdata  = c;
        len_wrow    = RW'(depth_reg);
        len_wdata   = LW'(pos_t1);
        rd_row      = RW'(depth_next - DW'(1));
        rd_col      = (pos_next < NAME_MAX) ? CW'(pos_next) : '0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TOP;
            depth_reg <= '0;
            pos_reg   <= '0;
            mis_reg   <= 1'b0;
            quote_reg <= 1'b0;
            pp_reg    <= PP_START;
            err_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            depth_reg <= depth_next;
            pos_reg   <= pos_next;
            mis_reg   <= last ? 1'b0 : mis_next;
            quote_reg <= last ? 1'b0 : quote_next;
            pp_reg    <= last ? PP_START : pp_next;
            err_reg   <= err_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

/* hw/rtl/xwc_out_buf.sv */
// result register with a skid stage toward the output channel
module xwc_out_buf
    import xwc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_data_reg;
    result_t skid_data_reg;
    logic    take;

    assign take = main_valid_reg && out_ready;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                main_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                main_data_reg <= push_data;
            end
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

/* hw/rtl/xml_wellformed_checker.sv */
// xml well-formedness checker, top level
//
// Input stream: one document byte per transfer on s_tdata, s_tlast high on
// the final byte of a document. Output stream: one verdict per document on
// m_tdata, doc_valid in bit 0 and over_capacity in bit 1.
// Throughput: one byte per clock cycle while s_tready is high. The close-tag compare
// reads the stack top from the name ram, and that read is issued together
// with the preceding byte, so no byte waits for memory.
// Output: the verdict is registered; with the output empty it is on m_tvalid in the cycle after the last byte is taken.
// Stalls: results sit in an output register backed by a one-entry skid
// stage; s_tready drops only while both hold a verdict, i.e. after two
// documents have finished without the receiver taking the first.
// Reset: parse state returns to top level with an empty stack; the name
// rams are not cleared and need no clearing pass, since a name byte or
// length is only read after this document wrote it. After each last byte
// the parser returns to the same state for the next document.
// Nesting depth and name length are set by MAX_DEPTH and MAX_NAME_LEN.
module xml_wellformed_checker
    import xwc_pkg::*;
#(
    parameter int MAX_DEPTH    = MAX_DEPTH_DEF,
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] doc_valid, [1] over_capacity, [7:2] zero
);

    localparam int RW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
    localparam int LW = $clog2(MAX_NAME_LEN + 1);

    logic          accept;
    stack_ctl_t    ctl;
    logic [RW-1:0] name_wrow;
    logic [CW-1:0] name_wcol;
    logic [7:0]    name_wdata;
    logic [RW-1:0] len_wrow;
    logic [LW-1:0] len_wdata;
    logic [RW-1:0] rd_row;
    logic [CW-1:0] rd_col;
    logic [7:0]    top_byte;
    logic [LW-1:0] top_len;
    logic          res_push;
    result_t       res;
    result_t       out_res;

    assign accept = s_tvalid && s_tready;

    xwc_parser #(
        .MAX_DEPTH    (MAX_DEPTH),
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .c          (s_tdata),
        .last       (s_tlast),
        .top_byte   (top_byte),
        .top_len    (top_len),
        .ctl        (ctl),
        .name_wrow  (name_wrow),
        .name_wcol  (name_wcol),
        .name_wdata (name_wdata),
        .len_wrow   (len_wrow),
        .len_wdata  (len_wdata),
        .rd_row     (rd_row),
        .rd_col     (rd_col),
        .res_push   (res_push),
        .res        (res)
    );

    xwc_name_stack #(
        .MAX_DEPTH    (MAX_DEPTH),
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_name_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .name_wrow  (name_wrow),
        .name_wcol  (name_wcol),
        .name_wdata (name_wdata),
        .len_wrow   (len_wrow),
        .len_wdata  (len_wdata),
        .rd_row     (rd_row),
        .rd_col     (rd_col),
        .top_byte   (top_byte),
        .top_len    (top_len)
    );

    xwc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // pack the verdict, padding to a byte
    assign m_tdata = {6'b0, out_res.over_capacity, out_res.doc_valid};

endmodule

/* hw/rtl/xwc_checker.sv */
// port-level assertions for the xml well-formedness checker, bound to the top
module xwc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled verdict holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict changed while stalled");

    // a last byte taken with the output empty gives a verdict next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast && !m_tvalid |=> m_tvalid)
        else $error("verdict missing after last byte");

    // a verdict appears only after a last byte transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("verdict without last byte");

    // input stalls only while a verdict is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending verdict");

    // an over-capacity document is never valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("valid verdict with over capacity");

endmodule

bind xml_wellformed_checker xwc_checker u_xwc_checker (.*);

/* bench/tb.sv */
// testbench for the xml well-formedness checker: byte stream in, one verdict per document out
import xwc_pkg::*;

// run of closing characters that ends a comment or cdata section
localparam logic [3:0] TAIL_FULL = 4'd2;
// a question mark was just seen inside a processing instruction
localparam logic [3:0] PI_QMARK_SEEN = 4'd1;

function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
endfunction

function automatic bit name_stop(input logic [7:0] c);
    return blank_char(c) || c == CH_GT || c == CH_SLASH || c == CH_EQ;
endfunction

// parser prediction plus the queue of verdicts still owed by the block
class verdict_board;
    phase_t     phase;
    logic [7:0] name_mem [MAX_DEPTH_DEF * MAX_NAME_LEN_DEF];
    int         name_len [MAX_DEPTH_DEF];
    int         depth;
    int         pos;
    bit         mismatch;
    bit         single_quote;
    logic [3:0] prefix;
    bit         failed;
    bit         overflowed;
    string      keyword = "CDATA";
    result_t    verdicts [$];
    int         errors;
    int         taken;

    function new();
        errors = 0;
        taken = 0;
        clear_state();
    endfunction

    function void clear_state();
        phase = PH_TOP;
        foreach (name_mem[i]) name_mem[i] = 8'h00;
        foreach (name_len[i]) name_len[i] = 0;
        depth = 0;
        pos = 0;
        mismatch = 0;
        single_quote = 0;
        prefix = PP_START;
        failed = 0;
        overflowed = 0;
    endfunction

    function void flag_overflow();
        overflowed = 1;
        failed = 1;
    endfunction

    // advance the parse by one byte; a byte that ends a name, or that follows '<' in an open tag, is handled again
    function void take_byte(input logic [7:0] c);
        bit again;
        bit skip;
        logic [3:0] nxt;
        int top;
        again = 1;
        while (again)
        begin
            again = 0;
            case (phase)
                PH_TOP:
                    if (c == CH_LT) phase = PH_LT;
                    else failed = 1;
                PH_LT:
                begin
                    pos = 0;
                    if (c == CH_SLASH)
                    begin
                        phase = PH_NAME_CLOSE;
                        mismatch = (depth == 0);
                    end
                    else
                    begin
                        phase = PH_NAME_OPEN;
                        prefix = PP_START;
                        again = 1;
                    end
                end
                PH_NAME_OPEN:
                    if (name_stop(c))
                    begin
                        if (pos == 0) failed = 1;
                        else if (pos > MAX_NAME_LEN_DEF) flag_overflow();
                        else
                        begin
                            phase = PH_ATTR_GAP;
                            again = 1;
                        end
                    end
                    else
                    begin
                        // markup prefix recognition while the name grows
                        nxt = PP_DEAD;
                        skip = 0;
                        if (prefix == PP_START)
                        begin
                            if (c == CH_BANG) nxt = PP_BANG;
                            else if (c == CH_QMARK)
                            begin
                                phase = PH_SKIP_PI;
                                skip = 1;
                            end
                        end
                        else if (prefix == PP_BANG)
                        begin
                            if (c == CH_DASH) nxt = PP_DASH;
                            else if (c == CH_LBRACK) nxt = PP_BRACKET;
                        end
                        else if (prefix == PP_DASH)
                        begin
                            if (c == CH_DASH)
                            begin
                                phase = PH_SKIP_COMMENT;
                                skip = 1;
                            end
                        end
                        else if (prefix >= PP_BRACKET && prefix < PP_CDATA_END)
                        begin
                            if (c == keyword[prefix - PP_BRACKET]) nxt = prefix + 4'd1;
                        end
                        else if (prefix == PP_CDATA_END)
                        begin
                            if (c == CH_LBRACK)
                            begin
                                phase = PH_SKIP_CDATA;
                                skip = 1;
                            end
                        end
                        if (skip) prefix = PP_START;
                        else
                        begin
                            prefix = nxt;
                            if (depth < MAX_DEPTH_DEF && pos < MAX_NAME_LEN_DEF)
                                name_mem[depth * MAX_NAME_LEN_DEF + pos] = c;
                            if (pos <= MAX_NAME_LEN_DEF) pos++;
                            if (pos > MAX_NAME_LEN_DEF && prefix == PP_DEAD) flag_overflow();
                        end
                    end
                PH_NAME_CLOSE:
                    if (name_stop(c))
                    begin
                        if (pos == 0) failed = 1;
                        else if (pos > MAX_NAME_LEN_DEF) flag_overflow();
                        else
                        begin
                            if (depth == 0 || pos != name_len[depth - 1]) mismatch = 1;
                            phase = PH_CLOSE_WS;
                            again = 1;
                        end
                    end
                    else
                    begin
                        // compare against the name on top of the stack
                        if (depth == 0) mismatch = 1;
                        else
                        begin
                            top = depth - 1;
                            if (pos >= name_len[top] ||
                                name_mem[top * MAX_NAME_LEN_DEF + pos] != c)
                                mismatch = 1;
                        end
                        if (pos <= MAX_NAME_LEN_DEF) pos++;
                        if (pos > MAX_NAME_LEN_DEF) flag_overflow();
                    end
                PH_CLOSE_WS:
                    if (!blank_char(c))
                    begin
                        if (c == CH_GT && !mismatch && depth > 0)
                        begin
                            depth--;
                            phase = PH_TOP;
                        end
                        else failed = 1;
                    end
                PH_ATTR_GAP:
                    if (!blank_char(c))
                    begin
                        if (c == CH_GT)
                        begin
                            if (depth >= MAX_DEPTH_DEF) flag_overflow();
                            else
                            begin
                                name_len[depth] = pos;
                                depth++;
                                phase = PH_TOP;
                            end
                        end
                        else if (c == CH_SLASH) phase = PH_SELF_SLASH;
                        else if (c == CH_EQ) phase = PH_VALUE_WS;
                        else phase = PH_ATTR_NAME;
                    end
                PH_ATTR_NAME:
                    if (c == CH_EQ) phase = PH_VALUE_WS;
                    else if (blank_char(c)) failed = 1;
                PH_VALUE_WS:
                    if (!blank_char(c))
                    begin
                        if (c == CH_DQUOTE)
                        begin
                            single_quote = 0;
                            phase = PH_QUOTED;
                        end
                        else if (c == CH_SQUOTE)
                        begin
                            single_quote = 1;
                            phase = PH_QUOTED;
                        end
                        else failed = 1;
                    end
                PH_QUOTED:
                    if (c == (single_quote ? CH_SQUOTE : CH_DQUOTE)) phase = PH_ATTR_GAP;
                PH_SELF_SLASH:
                    if (c == CH_GT) phase = PH_TOP;
                    else failed = 1;
                PH_SKIP_COMMENT, PH_SKIP_CDATA:
                    if (c == (phase == PH_SKIP_COMMENT ? CH_DASH : CH_RBRACK))
                    begin
                        if (prefix < TAIL_FULL) prefix = prefix + 4'd1;
                    end
                    else if (c == CH_GT && prefix == TAIL_FULL) phase = PH_TOP;
                    else prefix = PP_START;
                PH_SKIP_PI:
                    if (c == CH_QMARK) prefix = PI_QMARK_SEEN;
                    else if (c == CH_GT && prefix == PI_QMARK_SEEN) phase = PH_TOP;
                    else prefix = PP_START;
                default:
                    failed = 1;
            endcase
        end
    endfunction

    // called for every accepted input transfer
    function void note_byte(input logic [7:0] c, input bit last);
        result_t want;
        taken++;
        if (!failed) take_byte(c);
        if (last)
        begin
            want.doc_valid = !failed && phase == PH_TOP && depth == 0;
            want.over_capacity = overflowed;
            verdicts.insert(verdicts.size(), want);
            clear_state();
        end
    endfunction

    task report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // called for every accepted output transfer
    task check_verdict(input logic [7:0] got);
        result_t want;
        if (verdicts.size() == 0)
            report($sformatf("verdict %02h arrived with none outstanding", got));
        else
        begin
            want = verdicts.pop_front();
            if (got[0] !== want.doc_valid)
                report($sformatf("doc_valid %b, predicted %b", got[0], want.doc_valid));
            if (got[1] !== want.over_capacity)
                report($sformatf("over_capacity %b, predicted %b", got[1],
                                 want.over_capacity));
            if (got[7:2] !== 6'd0)
                report($sformatf("padding bits %b not zero", got[7:2]));
        end
    endtask

    function int pending_verdicts();
        return verdicts.size();
    endfunction
endclass

module tb;
    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    verdict_board board;

    // document under construction and the generator's own tag stack
    logic [7:0] doc_q [$];
    logic [7:0] gen_name [0:17][0:35];
    int         gen_len [0:17];

    bit tx_idle;
    bit rx_idle;
    int rx_hold;

    xml_wellformed_checker DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    // verdict sink with random stall bursts
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) board.check_verdict(m_tdata);
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (rx_idle && $urandom_range(0, 7) == 0)
        begin
            rx_hold = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // one input transfer, with an occasional idle burst ahead of it
    task automatic send_byte(input logic [7:0] c, input bit last);
        if (tx_idle && $urandom_range(0, 9) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        board.note_byte(c, last);
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (board.pending_verdicts() > 0) @(posedge clk);
    endtask

    // append one byte to the document
    task automatic put_byte(input logic [7:0] b);
        doc_q.insert(doc_q.size(), b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic send_text(input string s);
        doc_q.delete();
        put_text(s);
        send_doc();
    endtask

    task automatic put_run(input logic [7:0] b, input int n);
        repeat (n) put_byte(b);
    endtask

    task automatic put_blanks(input int most);
        int n;
        n = $urandom_range(0, most);
        repeat (n)
            case ($urandom_range(0, 3))
                0: put_byte(CH_SPACE);
                1: put_byte(CH_TAB);
                2: put_byte(CH_LF);
                default: put_byte(CH_CR);
            endcase
    endtask

    // tag name at nesting level lvl; a letter first so no markup prefix forms
    task automatic put_name(input int lvl, input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            if (i == 0) b = 8'h61 + 8'($urandom_range(0, 25));
            else
                do b = 8'($urandom_range(0, 255)); while (name_stop(b));
            gen_name[lvl][i] = b;
            put_byte(b);
        end
        gen_len[lvl] = len;
    endtask

    // zero to two attributes with quoted values of random bytes
    task automatic put_attrs();
        int count;
        int n;
        logic [7:0] b;
        logic [7:0] q;
        count = $urandom_range(0, 2);
        repeat (count)
        begin
            put_byte(CH_SPACE);
            put_blanks(1);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
            begin
                do b = 8'($urandom_range(0, 255));
                while (i == 0 ? name_stop(b) : (b == CH_EQ || blank_char(b)));
                put_byte(b);
            end
            put_byte(CH_EQ);
            put_blanks(1);
            q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            put_byte(q);
            n = $urandom_range(0, 5);
            repeat (n)
            begin
                do b = 8'($urandom_range(0, 255)); while (b == q);
                put_byte(b);
            end
            put_byte(q);
        end
        put_blanks(1);
    endtask

    // comment, processing instruction or cdata section with random body
    task automatic put_misc();
        int kind;
        int n;
        logic [7:0] b;
        logic [7:0] stop;
        kind = $urandom_range(0, 2);
        if (kind == 0) put_text("<!--");
        else if (kind == 1) put_text("<?");
        else put_text("<![CDATA[");
        stop = kind == 0 ? CH_DASH : (kind == 1 ? CH_QMARK : CH_RBRACK);
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            do b = 8'($urandom_range(0, 255)); while (b == stop);
            put_byte(b);
        end
        if (kind == 0) put_text("-->");
        else if (kind == 1) put_text("?>");
        else put_text("]]>");
    endtask

    // well-formed document; dive opens a straight chain of tags
    task automatic build_doc(input int nest_cap, input int len_lo, input int len_hi,
                             input int tags, input bit dive);
        int d;
        int budget;
        doc_q.delete();
        d = 0;
        budget = tags;
        while (budget > 0 || d > 0)
        begin
            if ($urandom_range(0, 5) == 0) put_misc();
            if (budget > 0 && d < nest_cap && (d == 0 || dive || $urandom_range(0, 2) != 0))
            begin
                budget--;
                put_byte(CH_LT);
                put_name(d, $urandom_range(len_lo, len_hi));
                put_attrs();
                if (!dive && $urandom_range(0, 3) == 0) put_text("/>");
                else
                begin
                    put_byte(CH_GT);
                    d++;
                end
            end
            else if (d > 0)
            begin
                d--;
                put_byte(CH_LT);
                put_byte(CH_SLASH);
                for (int i = 0; i < gen_len[d]; i++) put_byte(gen_name[d][i]);
                put_blanks(1);
                put_byte(CH_GT);
            end
        end
        if ($urandom_range(0, 3) == 0) put_misc();
    endtask

    // one random corruption of the current document
    task automatic spoil_doc();
        int at;
        at = $urandom_range(0, doc_q.size() - 1);
        case ($urandom_range(0, 3))
            0: doc_q[at] = 8'($urandom_range(0, 255));
            1: while (doc_q.size() > at + 1) doc_q.delete(doc_q.size() - 1);
            2: doc_q.insert(at, $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(0, 255)));
            default: if (doc_q.size() > 1) doc_q.delete(at);
        endcase
    endtask

    initial
    begin
        int pick;
        bit late;
        board = new();
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        s_tlast <= 1'b0;
        m_tready <= 1'b0;
        tx_idle = 0;
        rx_idle = 0;
        rx_hold = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed documents: markup forms, attribute rules and error cases
        tx_idle = 1;
        rx_idle = 1;
        send_text("<a></a>");
        send_text("<a\tb='1'\nc=\"'\"\015/>");
        send_text("<!--a-b---><?p ??><![CDATA[x]]]><r/>");
        send_text("<!x></!x><![CDAX/>");
        send_text("<a ='v' b>c=''/>");
        send_text("<a b ='1'/>");
        send_text("<a b=v/>");
        send_text("<>");
        send_text("</>");
        send_text("</a>");
        send_text("<ab></a>");
        send_text("<a></ab>");
        send_text("<a></a\t>");
        send_text("<a/ >");
        send_text("<a/> ");
        send_text("<a/>x<b/>");
        send_text("<a>");
        send_text("<");
        send_text("<!--x");
        send_text("<?x?");
        send_text("<![CDATA[x]]");
        send_text("<a b='x");
        // extreme byte values inside a name
        doc_q.delete();
        put_text("<");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("></");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text(">");
        send_doc();
        // longest name, then one byte too long
        for (int n = MAX_NAME_LEN_DEF; n <= MAX_NAME_LEN_DEF + 1; n++)
        begin
            doc_q.delete();
            put_text("<");
            put_run("n", n);
            put_text("/>");
            send_doc();
        end
        doc_q.delete();
        put_text("<a></");
        put_run("a", MAX_NAME_LEN_DEF + 1);
        put_text(">");
        send_doc();
        // deepest nesting, then one level too deep
        for (int n = MAX_DEPTH_DEF; n <= MAX_DEPTH_DEF + 1; n++)
        begin
            doc_q.delete();
            repeat (n) put_text("<d>");
            repeat (n) put_text("</d>");
            send_doc();
        end
        hold_until_drained();

        // random documents, mostly well-formed
        while (board.taken < 1350)
        begin
            late = board.taken > 1150;
            tx_idle = !late && $urandom_range(0, 3) != 0;
            rx_idle = !late && $urandom_range(0, 3) != 0;
            pick = $urandom_range(0, 99);
            if (pick < 62)
                build_doc(5, 1, 6, $urandom_range(1, 6), 0);
            else if (pick < 66)
                build_doc(MAX_DEPTH_DEF + 1, 1, 3,
                          $urandom_range(MAX_DEPTH_DEF - 2, MAX_DEPTH_DEF + 1), 1);
            else if (pick < 72)
                build_doc(3, MAX_NAME_LEN_DEF - 4, MAX_NAME_LEN_DEF + 2,
                          $urandom_range(1, 3), 0);
            else if (pick < 94)
            begin
                build_doc(4, 1, 5, $urandom_range(1, 5), 0);
                spoil_doc();
            end
            else
            begin
                doc_q.delete();
                repeat ($urandom_range(1, 10))
                    put_byte($urandom_range(0, 2) == 0 ? CH_LT :
                             8'($urandom_range(0, 255)));
            end
            send_doc();
            if ($urandom_range(0, 24) == 0) hold_until_drained();
        end

        hold_until_drained();
        repeat (4) @(posedge clk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
